// ===== rtl/ths_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the tcp handshake scan detector
// no dependencies

package ths_pkg;

    localparam int IP_W    = 32;
    localparam int PORT_W  = 16;
    localparam int SEQ_W   = 32;
    localparam int SCORE_W = 19;
    localparam int THR_W   = 16;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 1;

    localparam logic [IP_W-1:0]  RESET_LOCAL_IP  = 32'hC0A8_3092;
    localparam logic [THR_W-1:0] RESET_THRESHOLD = 16'd10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOCAL_IP        = 1'b0,
        CFG_ALERT_THRESHOLD = 1'b1
    } cfg_idx_t;

    // event codes, also used as connection states
    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_SYN    = 3'd1,
        EV_SYNACK = 3'd2,
        EV_FULL   = 3'd3,
        EV_DATA   = 3'd4,
        EV_RESET  = 3'd5,
        EV_FIN    = 3'd6,
        EV_HALF   = 3'd7
    } ev_t;

    typedef enum logic [2:0] {
        RULE_NONE       = 3'd0,
        RULE_IN_SYN     = 3'd1,
        RULE_OUT_SYNACK = 3'd2,
        RULE_IN_ACK     = 3'd3,
        RULE_IN_RST     = 3'd4,
        RULE_OUT_RST    = 3'd5,
        RULE_OUT_DATA   = 3'd6,
        RULE_IN_FIN     = 3'd7
    } rule_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_EXEC,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/tcp_handshake_scan_detector.sv =====
`timescale 1ns / 1ps
// tcp handshake scan detector top level: host table, connection memory, counters
// depends on ths_pkg
//
// Usage: one parsed tcp header enters per word on the s_ channel (valid/ready);
// one result word leaves per input word on the m_ channel (valid/ready).
// Configuration (local_ip, alert_threshold) is written through cfg_we,
// cfg_index and cfg_wdata while the block is idle; writes take effect at once.
// Each word walks four steps: capture and rule decode, host search with the
// memory reads, state and counter update with write-back, score and output
// load. The result is registered and shows on m_valid after the output load;
// a new word is taken only after the last one has been loaded into the output
// register, as the steps run in sequence through the shared memories.
// After reset the connection memory is cleared one entry a cycle; s_ready stays
// low meanwhile. Configuration returns to its reset values and the host table
// empties.
// When the receiver stalls, the result is held in the output register and
// the block holds the next word in its last step until the register frees.

module tcp_handshake_scan_detector
    import ths_pkg::*;
#(
    parameter int HOSTS        = 16,
    parameter int CONN_ENTRIES = 1024,
    parameter int COUNT_BITS   = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,

    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_W-1:0]          cfg_wdata,

    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [IP_W-1:0]           s_src_ip,
    input  logic [IP_W-1:0]           s_dst_ip,
    input  logic [PORT_W-1:0]         s_src_port,
    input  logic [PORT_W-1:0]         s_dst_port,
    input  logic                      s_syn_flag,
    input  logic                      s_ack_flag,
    input  logic                      s_rst_flag,
    input  logic                      s_fin_flag,
    input  logic [SEQ_W-1:0]          s_seq_num,

    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [IP_W-1:0]           m_host_ip,
    output logic [2:0]                m_event_res,
    output logic                      m_counted,
    output logic signed [SCORE_W-1:0] m_score,
    output logic                      m_alert,
    output logic                      m_table_full
);

    localparam int SLOT_W = (HOSTS > 1) ? $clog2(HOSTS) : 1;
    localparam int IDX_W  = $clog2(CONN_ENTRIES);
    localparam int TAG_W  = SLOT_W + PORT_W;
    localparam int STRIDE = CONN_ENTRIES / HOSTS;
    localparam int SUM_W  = COUNT_BITS + 3;
    localparam int WIDE_W = (SUM_W > SCORE_W) ? SUM_W : SCORE_W + 1;

    localparam logic signed [WIDE_W-1:0] SCORE_MAX = WIDE_W'((2 ** (SCORE_W - 1)) - 1);
    localparam logic signed [WIDE_W-1:0] SCORE_MIN = -SCORE_MAX - WIDE_W'(1);

    typedef struct packed {
        logic [COUNT_BITS-1:0] syn;
        logic [COUNT_BITS-1:0] full;
        logic [COUNT_BITS-1:0] half;
        logic [COUNT_BITS-1:0] rst;
        logic [COUNT_BITS-1:0] data;
    } cnt_t;

    typedef struct packed {
        logic             valid;
        logic [TAG_W-1:0] tag;
        logic [2:0]       st;
    } conn_t;

    // configuration
    logic [IP_W-1:0]  local_ip_reg;
    logic [THR_W-1:0] threshold_reg;

    // control
    state_t           state_reg, state_next;
    logic [IDX_W-1:0] clr_reg;

    // host table
    logic             host_valid_reg [HOSTS];
    logic [IP_W-1:0]  host_addr_reg  [HOSTS];

    // memories
    conn_t            conn_mem [CONN_ENTRIES];
    cnt_t             cnt_mem  [HOSTS];
    conn_t            conn_rd_reg;
    cnt_t             cnt_rd_reg;

    // word in flight
    rule_t            rule_reg;
    logic [IP_W-1:0]  host_reg;
    logic [PORT_W-1:0] port_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic             new_reg;
    logic             full_reg;
    logic [IDX_W-1:0] idx_reg;
    ev_t              ev_reg;
    logic             counted_reg;
    cnt_t             cnt_new_reg;

    // output register
    logic                      m_valid_reg;
    logic [IP_W-1:0]           host_ip_reg;
    logic [2:0]                event_res_reg;
    logic                      counted_out_reg;
    logic signed [SCORE_W-1:0] score_reg;
    logic                      alert_reg;
    logic                      table_full_reg;

    // ---------------- rule decode at capture ----------------
    logic              incoming;
    logic              seq_nz;
    rule_t             rule_dec;
    logic [IP_W-1:0]   host_dec;
    logic [PORT_W-1:0] port_dec;

    always_comb begin
        incoming = (s_src_ip != local_ip_reg);
        seq_nz   = (s_seq_num != '0);
        if (incoming && s_syn_flag && !s_ack_flag) begin
            rule_dec = RULE_IN_SYN;
        end else if (!incoming && s_syn_flag && s_ack_flag) begin
            rule_dec = RULE_OUT_SYNACK;
        end else if (incoming && s_ack_flag && seq_nz) begin
            rule_dec = RULE_IN_ACK;
        end else if (incoming && s_rst_flag) begin
            rule_dec = RULE_IN_RST;
        end else if (!incoming && s_rst_flag) begin
            rule_dec = RULE_OUT_RST;
        end else if (!incoming && (s_dst_ip != local_ip_reg) && s_ack_flag && seq_nz) begin
            rule_dec = RULE_OUT_DATA;
        end else if (incoming && s_fin_flag && !s_ack_flag) begin
            rule_dec = RULE_IN_FIN;
        end else begin
            rule_dec = RULE_NONE;
        end
        host_dec = incoming ? s_src_ip : s_dst_ip;
        port_dec = incoming ? s_dst_port : s_src_port;
    end

    // ---------------- host search ----------------
    logic              hit_any, free_any;
    logic [SLOT_W-1:0] hit_slot, free_slot, slot_look;
    logic [IDX_W-1:0]  idx_look;
    logic [31:0]       idx_sum;

    always_comb begin
        hit_any   = 1'b0;
        free_any  = 1'b0;
        hit_slot  = '0;
        free_slot = '0;
        for (int i = HOSTS - 1; i >= 0; i--) begin
            if (host_valid_reg[i] && (host_addr_reg[i] == host_reg)) begin
                hit_any  = 1'b1;
                hit_slot = SLOT_W'(i);
            end
            if (!host_valid_reg[i]) begin
                free_any  = 1'b1;
                free_slot = SLOT_W'(i);
            end
        end
        slot_look = hit_any ? hit_slot : free_slot;
        idx_sum   = 32'(port_reg) + 32'(slot_look) * 32'(STRIDE);
        idx_look  = idx_sum[IDX_W-1:0];
    end

    // ---------------- connection update ----------------
    logic [TAG_W-1:0] tag_cur;
    ev_t              cur;
    ev_t              nst;
    logic             wr_conn;
    logic             cnt_flag;
    logic             act;
    cnt_t             base;
    cnt_t             cnt_upd;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
        sat_inc = (c == '1) ? c : c + 1'b1;
    endfunction

    always_comb begin
        tag_cur  = {slot_reg, port_reg};
        cur      = (conn_rd_reg.valid && (conn_rd_reg.tag == tag_cur)) ?
                   ev_t'(conn_rd_reg.st) : EV_NONE;
        base     = new_reg ? '0 : cnt_rd_reg;
        cnt_upd  = base;
        nst      = EV_NONE;
        wr_conn  = 1'b0;
        cnt_flag = 1'b0;
        act      = (rule_reg != RULE_NONE) && !full_reg;
        case (rule_reg)
            RULE_IN_SYN: begin
                nst         = EV_SYN;
                wr_conn     = 1'b1;
                cnt_upd.syn = sat_inc(base.syn);
            end
            RULE_OUT_SYNACK: begin
                if (cur == EV_SYN) begin
                    nst     = EV_SYNACK;
                    wr_conn = 1'b1;
                end
            end
            RULE_IN_ACK: begin
                if (cur == EV_SYNACK) begin
                    nst          = EV_FULL;
                    wr_conn      = 1'b1;
                    cnt_flag     = 1'b1;
                    cnt_upd.full = sat_inc(base.full);
                end else if (cur == EV_FULL) begin
                    nst          = EV_DATA;
                    wr_conn      = 1'b1;
                    cnt_flag     = 1'b1;
                    cnt_upd.data = sat_inc(base.data);
                end
            end
            RULE_IN_RST: begin
                if (cur == EV_SYNACK) begin
                    nst          = EV_HALF;
                    wr_conn      = 1'b1;
                    cnt_flag     = 1'b1;
                    cnt_upd.half = sat_inc(base.half);
                end
            end
            RULE_OUT_RST: begin
                if ((cur == EV_SYN) || (cur == EV_FIN)) begin
                    nst         = EV_RESET;
                    wr_conn     = 1'b1;
                    cnt_flag    = 1'b1;
                    cnt_upd.rst = sat_inc(base.rst);
                end
            end
            RULE_OUT_DATA: begin
                if (cur == EV_FULL) begin
                    nst          = EV_DATA;
                    wr_conn      = 1'b1;
                    cnt_flag     = 1'b1;
                    cnt_upd.data = sat_inc(base.data);
                end
            end
            RULE_IN_FIN: begin
                nst     = EV_FIN;
                wr_conn = 1'b1;
            end
            default: begin
                nst = EV_NONE;
            end
        endcase
    end

    // ---------------- score ----------------
    logic signed [WIDE_W-1:0]  sum_wide;
    logic signed [SCORE_W-1:0] score_sat;
    logic signed [SCORE_W-1:0] thr_ext;
    logic                      load_out;

    always_comb begin
        sum_wide = signed'(WIDE_W'(cnt_new_reg.full)) + signed'(WIDE_W'(cnt_new_reg.half))
                 + signed'(WIDE_W'(cnt_new_reg.rst))  - signed'(WIDE_W'(cnt_new_reg.data));
        if (sum_wide > SCORE_MAX) begin
            score_sat = SCORE_MAX[SCORE_W-1:0];
        end else if (sum_wide < SCORE_MIN) begin
            score_sat = SCORE_MIN[SCORE_W-1:0];
        end else begin
            score_sat = sum_wide[SCORE_W-1:0];
        end
        thr_ext = signed'(SCORE_W'(threshold_reg));
    end

    // ---------------- state machine ----------------
    logic             conn_we;
    logic [IDX_W-1:0] conn_waddr;
    conn_t            conn_wdata;
    logic             cnt_we;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        conn_we    = 1'b0;
        conn_waddr = idx_reg;
        conn_wdata = '{valid: 1'b1, tag: tag_cur, st: nst};
        cnt_we     = 1'b0;
        load_out   = 1'b0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                conn_we    = 1'b1;
                conn_waddr = clr_reg;
                conn_wdata = '0;
                if (clr_reg == IDX_W'(CONN_ENTRIES - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK: begin
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                conn_we    = act && wr_conn;
                cnt_we     = act;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else if (state_reg == ST_CLEAR) begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    // ---------------- configuration ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            local_ip_reg  <= RESET_LOCAL_IP;
            threshold_reg <= RESET_THRESHOLD;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_LOCAL_IP:        local_ip_reg  <= cfg_wdata[IP_W-1:0];
                CFG_ALERT_THRESHOLD: threshold_reg <= cfg_wdata[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- host table ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < HOSTS; i++) begin
                host_valid_reg[i] <= 1'b0;
            end
        end else if ((state_reg == ST_EXEC) && act && new_reg) begin
            host_valid_reg[slot_reg] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_EXEC) && act && new_reg) begin
            host_addr_reg[slot_reg] <= host_reg;
        end
    end

    // ---------------- memories ----------------
    always_ff @(posedge aclk) begin
        if (conn_we) begin
            conn_mem[conn_waddr] <= conn_wdata;
        end
        if (state_reg == ST_LOOK) begin
            conn_rd_reg <= conn_mem[idx_look];
        end
    end

    always_ff @(posedge aclk) begin
        if (cnt_we) begin
            cnt_mem[slot_reg] <= cnt_upd;
        end
        if (state_reg == ST_LOOK) begin
            cnt_rd_reg <= cnt_mem[slot_look];
        end
    end

    // ---------------- word in flight ----------------
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            rule_reg <= rule_dec;
            host_reg <= host_dec;
            port_reg <= port_dec;
        end
        if (state_reg == ST_LOOK) begin
            slot_reg <= slot_look;
            new_reg  <= !hit_any;
            full_reg <= !hit_any && !free_any;
            idx_reg  <= idx_look;
        end
        if (state_reg == ST_EXEC) begin
            ev_reg      <= wr_conn ? nst : EV_NONE;
            counted_reg <= cnt_flag;
            cnt_new_reg <= cnt_upd;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            if (rule_reg == RULE_NONE) begin
                host_ip_reg     <= '0;
                event_res_reg   <= EV_NONE;
                counted_out_reg <= 1'b0;
                score_reg       <= '0;
                alert_reg       <= 1'b0;
                table_full_reg  <= 1'b0;
            end else if (full_reg) begin
                host_ip_reg     <= host_reg;
                event_res_reg   <= EV_NONE;
                counted_out_reg <= 1'b0;
                score_reg       <= '0;
                alert_reg       <= 1'b0;
                table_full_reg  <= 1'b1;
            end else begin
                host_ip_reg     <= host_reg;
                event_res_reg   <= ev_reg;
                counted_out_reg <= counted_reg;
                score_reg       <= score_sat;
                alert_reg       <= counted_reg && (score_sat > thr_ext);
                table_full_reg  <= 1'b0;
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_host_ip    = host_ip_reg;
    assign m_event_res  = event_res_reg;
    assign m_counted    = counted_out_reg;
    assign m_score      = score_reg;
    assign m_alert      = alert_reg;
    assign m_table_full = table_full_reg;

    // ---------------- assertions ----------------
    a_alert_needs_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_alert || m_counted))
        else $error("alert without a counted transition");

    a_full_is_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_table_full) |->
            ((m_event_res == EV_NONE) && !m_counted && (m_score == '0) && !m_alert))
        else $error("table full word carries state fields");

    a_load_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result loaded outside the output step");

    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_ready)
        else $error("input taken during memory clear");

    a_count_write_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_we |-> ((state_reg == ST_EXEC) && !full_reg))
        else $error("counter write outside the update step");

endmodule
